FILE: rtl/pre_pkg.sv
// Shared types, widths and codes for the page replacement engine.
package pre_pkg;

    // Sizes (both must be powers of two)
    localparam int NUM_PAGES    = 64;
    localparam int NUM_FRAMES   = 8;
    localparam int PAGE_W       = $clog2(NUM_PAGES);
    localparam int FRAME_W      = $clog2(NUM_FRAMES);

    // Port field widths
    localparam int PAGE_PORT_W  = 6;
    localparam int FRAME_PORT_W = 3;
    localparam int OP_W         = 2;
    localparam int POLICY_W     = 2;
    localparam int COUNT_W      = 32;

    // Clock sweep bound: three turns of the hand
    localparam int SWEEP_MAX    = 3 * NUM_FRAMES;
    localparam int SWEEP_W      = $clog2(SWEEP_MAX + 1);

    // Page flag layout
    localparam int FLAG_W       = 4;
    localparam int PRESENT_BIT  = 0;
    localparam logic [FLAG_W-1:0] FL_PRESENT = 4'b0001;
    localparam logic [FLAG_W-1:0] FL_DIRTY   = 4'b0010;
    localparam logic [FLAG_W-1:0] FL_USED    = 4'b0100;
    localparam logic [FLAG_W-1:0] FL_USED1   = 4'b1000;

    // Opcodes
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_FAULT = 2'd2;

    // Replacement policies
    localparam logic [POLICY_W-1:0] POL_FIFO   = 2'd0;
    localparam logic [POLICY_W-1:0] POL_CLOCK  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_CLOCK2 = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SWEEP_RD,
        S_SWEEP_CHK,
        S_VICTIM,
        S_EVICT,
        S_LOAD,
        S_FINISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // latch the input beat
        logic rd_en;       // read flag memory
        logic rd_hand;     // read address is the page under the hand
        logic lookup;      // evaluate the item against its page entry
        logic sweep_step;  // clear a reference bit and advance the hand
        logic victim;      // take the frame under the hand
        logic evict;       // drop the victim page
        logic load;        // install the requested page
        logic emit;        // move the result into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            present;
        logic            has_free;
        logic            clock_pol;
        logic            sweep_used;
        logic            sweep_done;
        logic            out_free;
    } sts_t;

endpackage

FILE: rtl/pre_ram.sv
// Generic single write port, single read port RAM with registered read.
module pre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pre_ctrl.sv
// Controller state machine that sequences lookup, clock sweep, eviction and load.
module pre_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pre_pkg::sts_t sts,
    output pre_pkg::cmd_t cmd
);

    pre_pkg::state_t state_reg;
    pre_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pre_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pre_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pre_pkg::S_LOOKUP;
                end
            end
            pre_pkg::S_LOOKUP:
            begin
                if (sts.op == pre_pkg::OP_FAULT && !sts.present)
                begin
                    if (sts.has_free)
                    begin
                        state_next = pre_pkg::S_LOAD;
                    end
                    else if (sts.clock_pol)
                    begin
                        state_next = pre_pkg::S_SWEEP_RD;
                    end
                    else
                    begin
                        state_next = pre_pkg::S_VICTIM;
                    end
                end
                else
                begin
                    state_next = pre_pkg::S_FINISH;
                end
            end
            pre_pkg::S_SWEEP_RD:
            begin
                if (sts.sweep_done)
                begin
                    state_next = pre_pkg::S_VICTIM;
                end
                else
                begin
                    state_next = pre_pkg::S_SWEEP_CHK;
                end
            end
            pre_pkg::S_SWEEP_CHK:
            begin
                if (sts.sweep_used)
                begin
                    state_next = pre_pkg::S_SWEEP_RD;
                end
                else
                begin
                    state_next = pre_pkg::S_VICTIM;
                end
            end
            pre_pkg::S_VICTIM: state_next = pre_pkg::S_EVICT;
            pre_pkg::S_EVICT:  state_next = pre_pkg::S_LOAD;
            pre_pkg::S_LOAD:   state_next = pre_pkg::S_FINISH;
            pre_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = pre_pkg::S_IDLE;
                end
            end
            default: state_next = pre_pkg::S_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            pre_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                cmd.rd_en   = in_valid;
            end
            pre_pkg::S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            pre_pkg::S_SWEEP_RD:
            begin
                cmd.rd_en   = !sts.sweep_done;
                cmd.rd_hand = 1'b1;
            end
            pre_pkg::S_SWEEP_CHK:
            begin
                cmd.sweep_step = sts.sweep_used;
            end
            pre_pkg::S_VICTIM:
            begin
                cmd.victim  = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_hand = 1'b1;
            end
            pre_pkg::S_EVICT:
            begin
                cmd.evict = 1'b1;
            end
            pre_pkg::S_LOAD:
            begin
                cmd.load = 1'b1;
            end
            pre_pkg::S_FINISH:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/pre_dp.sv
// Datapath: page flag and frame memories, frame owner map, clock hand, counters, output register.
module pre_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pre_pkg::cmd_t                     cmd,
    output pre_pkg::sts_t                     sts,
    input  logic [pre_pkg::OP_W-1:0]          opcode,
    input  logic [pre_pkg::PAGE_PORT_W-1:0]   page_number,
    input  logic                              cfg_valid,
    input  logic [pre_pkg::POLICY_W-1:0]      policy_mode,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              hit,
    output logic [pre_pkg::FRAME_PORT_W-1:0]  frame,
    output logic                              replaced_valid,
    output logic [pre_pkg::PAGE_PORT_W-1:0]   evicted_page,
    output logic                              write_back,
    output logic [pre_pkg::COUNT_W-1:0]       fault_total
);

    localparam int PW = pre_pkg::PAGE_W;
    localparam int FW = pre_pkg::FRAME_W;
    localparam int GW = pre_pkg::FLAG_W;

    // Control state
    logic [pre_pkg::POLICY_W-1:0] policy_reg;
    logic [FW-1:0]                hand_reg;
    logic [FW-1:0]                hand_next;
    logic [pre_pkg::COUNT_W-1:0]  fault_count_reg;
    logic [pre_pkg::NUM_FRAMES-1:0] owner_vld_reg;
    logic [pre_pkg::NUM_PAGES-1:0]  flag_vld_reg;
    logic                         rd_vld_reg;
    logic [pre_pkg::SWEEP_W-1:0]  sweep_cnt_reg;
    logic                         out_valid_reg;

    // Payload
    logic [PW-1:0]                owner_page_reg [pre_pkg::NUM_FRAMES];
    logic [pre_pkg::OP_W-1:0]     op_reg;
    logic [PW-1:0]                pg_reg;
    logic [GW-1:0]                cur_flags_reg;
    logic [FW-1:0]                f_reg;
    logic [PW-1:0]                rep_page_reg;
    logic                         res_hit_reg;
    logic [FW-1:0]                res_frame_reg;
    logic                         res_rep_valid_reg;
    logic                         res_wb_reg;
    logic                         out_hit_reg;
    logic [FW-1:0]                out_frame_reg;
    logic                         out_rep_valid_reg;
    logic [PW-1:0]                out_rep_page_reg;
    logic                         out_wb_reg;
    logic [pre_pkg::COUNT_W-1:0]  out_count_reg;

    // Combinational
    logic [PW-1:0]  in_pg;
    logic [PW-1:0]  owner_hand;
    logic [PW-1:0]  fl_raddr;
    logic           fl_we;
    logic [PW-1:0]  fl_waddr;
    logic [GW-1:0]  fl_wdata;
    logic [GW-1:0]  fl_rdata;
    logic [GW-1:0]  flags_q;
    logic [FW-1:0]  frame_q;
    logic           has_free;
    logic [FW-1:0]  free_idx;
    logic           is_access;
    logic           present;

    assign in_pg      = PW'(page_number);
    assign owner_hand = owner_page_reg[hand_reg];
    assign fl_raddr   = cmd.rd_hand ? owner_hand : in_pg;
    assign flags_q    = rd_vld_reg ? fl_rdata : '0;
    assign present    = flags_q[pre_pkg::PRESENT_BIT];
    assign is_access  = (op_reg == pre_pkg::OP_READ) || (op_reg == pre_pkg::OP_WRITE);
    assign hand_next  = (hand_reg == FW'(pre_pkg::NUM_FRAMES - 1)) ? '0 : hand_reg + FW'(1);

    // Lowest free frame
    always_comb
    begin
        has_free = 1'b0;
        free_idx = '0;
        for (int i = pre_pkg::NUM_FRAMES - 1; i >= 0; i--)
        begin
            if (!owner_vld_reg[i])
            begin
                has_free = 1'b1;
                free_idx = FW'(i);
            end
        end
    end

    // Flag memory write selection
    always_comb
    begin
        fl_we    = 1'b0;
        fl_waddr = pg_reg;
        fl_wdata = flags_q;
        if (cmd.lookup && is_access && present)
        begin
            fl_we    = 1'b1;
            fl_wdata = flags_q | pre_pkg::FL_USED | pre_pkg::FL_USED1
                     | ((op_reg == pre_pkg::OP_WRITE) ? pre_pkg::FL_DIRTY : '0);
        end
        else if (cmd.sweep_step)
        begin
            fl_we    = 1'b1;
            fl_waddr = owner_hand;
            if (policy_reg == pre_pkg::POL_CLOCK2 && (flags_q & pre_pkg::FL_USED1) != '0)
            begin
                fl_wdata = flags_q & ~pre_pkg::FL_USED1;
            end
            else
            begin
                fl_wdata = flags_q & ~pre_pkg::FL_USED;
            end
        end
        else if (cmd.evict)
        begin
            fl_we    = 1'b1;
            fl_waddr = rep_page_reg;
            fl_wdata = flags_q & ~(pre_pkg::FL_PRESENT | pre_pkg::FL_DIRTY);
        end
        else if (cmd.load)
        begin
            fl_we    = 1'b1;
            fl_waddr = pg_reg;
            fl_wdata = (cur_flags_reg | pre_pkg::FL_PRESENT | pre_pkg::FL_USED)
                     & ~pre_pkg::FL_DIRTY;
        end
    end

    pre_ram #(
        .WIDTH (GW),
        .DEPTH (pre_pkg::NUM_PAGES)
    ) u_flag_ram (
        .clk   (clk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .re    (cmd.rd_en),
        .raddr (fl_raddr),
        .rdata (fl_rdata)
    );

    pre_ram #(
        .WIDTH (FW),
        .DEPTH (pre_pkg::NUM_PAGES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (pg_reg),
        .wdata (f_reg),
        .re    (cmd.capture),
        .raddr (in_pg),
        .rdata (frame_q)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg      <= pre_pkg::POL_FIFO;
            hand_reg        <= '0;
            fault_count_reg <= '0;
            owner_vld_reg   <= '0;
            flag_vld_reg    <= '0;
            rd_vld_reg      <= 1'b0;
            sweep_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                policy_reg <= policy_mode;
            end
            // Mark written flag entries; unwritten ones read as zero
            if (fl_we)
            begin
                flag_vld_reg[fl_waddr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_vld_reg <= flag_vld_reg[fl_raddr];
            end
            if (cmd.lookup)
            begin
                sweep_cnt_reg <= '0;
                if (op_reg == pre_pkg::OP_FAULT)
                begin
                    fault_count_reg <= fault_count_reg + 1'b1;
                end
            end
            // Advance the hand past a second-chance page or a taken victim
            if (cmd.sweep_step)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                hand_reg      <= hand_next;
            end
            if (cmd.victim)
            begin
                hand_reg <= hand_next;
            end
            if (cmd.load)
            begin
                owner_vld_reg[f_reg] <= 1'b1;
            end
            // Output register: fill on emit, drain on accepted beat
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= opcode;
            pg_reg <= in_pg;
        end
        if (cmd.lookup)
        begin
            cur_flags_reg     <= flags_q;
            f_reg             <= free_idx;
            res_hit_reg       <= present && (is_access || op_reg == pre_pkg::OP_FAULT);
            res_frame_reg     <= (present && (is_access || op_reg == pre_pkg::OP_FAULT))
                               ? frame_q : '0;
            res_rep_valid_reg <= 1'b0;
            rep_page_reg      <= '0;
            res_wb_reg        <= 1'b0;
        end
        if (cmd.victim)
        begin
            f_reg             <= hand_reg;
            rep_page_reg      <= owner_hand;
            res_rep_valid_reg <= 1'b1;
        end
        if (cmd.evict)
        begin
            res_wb_reg <= (flags_q & pre_pkg::FL_DIRTY) != '0;
        end
        if (cmd.load)
        begin
            owner_page_reg[f_reg] <= pg_reg;
            res_frame_reg         <= f_reg;
        end
        if (cmd.emit)
        begin
            out_hit_reg       <= res_hit_reg;
            out_frame_reg     <= res_frame_reg;
            out_rep_valid_reg <= res_rep_valid_reg;
            out_rep_page_reg  <= rep_page_reg;
            out_wb_reg        <= res_wb_reg;
            out_count_reg     <= fault_count_reg;
        end
    end

    // Status to controller
    always_comb
    begin
        sts            = '0;
        sts.op         = op_reg;
        sts.present    = present;
        sts.has_free   = has_free;
        sts.clock_pol  = (policy_reg == pre_pkg::POL_CLOCK) || (policy_reg == pre_pkg::POL_CLOCK2);
        sts.sweep_used = (flags_q & pre_pkg::FL_USED) != '0;
        sts.sweep_done = (sweep_cnt_reg == pre_pkg::SWEEP_W'(pre_pkg::SWEEP_MAX));
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // Result ports
    assign out_valid      = out_valid_reg;
    assign hit            = out_hit_reg;
    assign frame          = pre_pkg::FRAME_PORT_W'(out_frame_reg);
    assign replaced_valid = out_rep_valid_reg;
    assign evicted_page   = pre_pkg::PAGE_PORT_W'(out_rep_page_reg);
    assign write_back     = out_wb_reg;
    assign fault_total    = out_count_reg;

    // A page is only loaded when it was absent at lookup
    a_load_absent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !cur_flags_reg[pre_pkg::PRESENT_BIT])
        else $error("load issued for a page that was already present");

    // A load leaves the frame owned by the requested page
    a_load_owner: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> owner_vld_reg[f_reg] && (owner_page_reg[f_reg] == pg_reg))
        else $error("frame owner map not updated by load");

    // Eviction only happens with every frame occupied
    a_victim_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.victim |-> (&owner_vld_reg))
        else $error("victim chosen while a free frame exists");

    // The fault counter moves only on a fault lookup
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.lookup && op_reg == pre_pkg::OP_FAULT) |=> $stable(fault_count_reg))
        else $error("fault counter changed outside a fault lookup");

endmodule

FILE: rtl/page_replacement_engine.sv
// Top level of the page replacement engine: controller plus datapath.
//
// Each input beat is a read access, write access or page fault on one virtual page and
// yields exactly one result beat; the engine accepts a new beat only back in idle.
// Accesses, faults on resident pages and unknown opcodes pass through lookup and
// finish. A fault that finds a free frame adds the load state; one that evicts under FIFO
// adds victim, evict and load. Under the clock policies each hand step takes a sweep read
// and a sweep check state, because the single flag memory read port must return a page's
// reference bits before the hand may move on. At most 2*NUM_FRAMES pages are skipped;
// the sweep counter would stop the sweep at 3*NUM_FRAMES. The result sits in an output
// register, so the engine takes a new beat while the last result still waits; the next
// result then holds the engine until out_ready drains the register. The policy
// register may be written only while no item is pending.
module page_replacement_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pre_pkg::POLICY_W-1:0]      policy_mode,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [pre_pkg::OP_W-1:0]          opcode,
    input  logic [pre_pkg::PAGE_PORT_W-1:0]   page_number,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              hit,
    output logic [pre_pkg::FRAME_PORT_W-1:0]  frame,
    output logic                              replaced_valid,
    output logic [pre_pkg::PAGE_PORT_W-1:0]   evicted_page,
    output logic                              write_back,
    output logic [pre_pkg::COUNT_W-1:0]       fault_total
);

    pre_pkg::cmd_t cmd;
    pre_pkg::sts_t sts;

    // Policy register is always writable
    assign cfg_ready = 1'b1;

    pre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pre_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (opcode),
        .page_number    (page_number),
        .cfg_valid      (cfg_valid),
        .policy_mode    (policy_mode),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit            (hit),
        .frame          (frame),
        .replaced_valid (replaced_valid),
        .evicted_page   (evicted_page),
        .write_back     (write_back),
        .fault_total    (fault_total)
    );

endmodule
